// ===== design/qtge_pkg.sv =====
// ----------------------------------------------------------------------------
// qtge_pkg
// shared widths, cordic lane word type and the arctangent table
// ----------------------------------------------------------------------------
`default_nettype none

package qtge_pkg;

    localparam int GW         = 20;   // unsaturated gravity, q14
    localparam int CW         = 40;   // cordic x / y
    localparam int AW         = 34;   // cordic angle accumulator, 2^31 = pi
    localparam int RW         = 38;   // square root radicand
    localparam int SQ_STAGES  = 19;   // result bits of the square root
    localparam int MAX_STAGES = 24;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] acc;
        logic                 zero;
    } cordic_t;

    function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/quaternion_to_gravity_euler.sv =====
// throughput: one word per cycle; the whole pipeline advances when the output
// register is empty or being taken
// stages: input register, products, gravity, squares, radicands, 19 square root cells,
// pre-rotation, CORDIC_STAGES cordic cells per angle (at most MAX_STAGES), output register
// reset clears all valid flags and the output valid; data registers are not reset
// ----------------------------------------------------------------------------
// quaternion_to_gravity_euler
// unit quaternion to gravity vector and roll, pitch, yaw angles
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_gravity_euler
    import qtge_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata    // gravity_x, gravity_y, gravity_z, roll, pitch, yaw
);

    localparam int NS = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    localparam int L  = 6 + SQ_STAGES + NS;
    localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;
    localparam logic signed [AW-1:0] PI_ACC = 34'sd2147483648;

    typedef struct packed {
        logic signed [GW-1:0] gx;
        logic signed [GW-1:0] gy;
        logic                 gz_pos;
        logic [47:0]          grav;
        logic signed [33:0]   yaw_y;
        logic signed [34:0]   yaw_x;
    } side_t;

    function automatic logic [15:0] sat16(input logic signed [GW-1:0] v);
        logic [15:0] r;
        if (v > 20'sd32767)
            r = 16'h7fff;
        else if (v < -20'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic cordic_t pre_rotate(input logic signed [CW-1:0] y,
                                           input logic signed [CW-1:0] x);
        cordic_t c;
        c.zero = (x == '0) && (y == '0);
        if (x[CW-1])
        begin
            c.acc = y[CW-1] ? -PI_ACC : PI_ACC;
            c.x   = -x;
            c.y   = -y;
        end
        else
        begin
            c.acc = '0;
            c.x   = x;
            c.y   = y;
        end
        return c;
    endfunction

    function automatic logic [15:0] angle_out(input cordic_t c);
        logic signed [AW-1:0] r;
        r = (c.acc + 34'sd32768) >>> 16;
        return c.zero ? 16'h0000 : r[15:0];
    endfunction

    logic en;
    logic [L-1:0] vld_reg;

    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg, xz_reg;
    logic signed [31:0] wy_reg, wx_reg, yz_reg, xy_reg, wz_reg;
    logic signed [33:0] gx28, gy28, gz28, yaw_y_next;
    logic signed [34:0] yaw_x_next;
    logic signed [33:0] gx_rnd, gy_rnd, gz_rnd;
    logic signed [GW-1:0] gx_reg, gy_reg, gz_reg;
    logic signed [33:0] yaw_y_reg;
    logic signed [34:0] yaw_x_reg;
    logic signed [2*GW-1:0] sqx, sqy, sqz;
    logic [RW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [RW+10:0] small_p, small_r;
    logic [RW-1:0] rad_p_reg, rad_r_reg;
    side_t side_s3_reg, side_s4_reg;
    side_t side_reg [SQ_STAGES];

    logic [RW-1:0] rem_p [SQ_STAGES];
    logic [RW-1:0] root_p [SQ_STAGES];
    logic [RW-1:0] rem_r [SQ_STAGES];
    logic [RW-1:0] root_r [SQ_STAGES];

    logic [47:0] grav_reg [NS+1];
    cordic_t pre_reg [3];
    cordic_t lane_q [3][NS];
    logic signed [CW-1:0] den_p, den_r;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= {vld_reg[L-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[L-1];
        end
    end

    always_comb
    begin
        gx28       = (34'(xz_reg) - 34'(wy_reg)) <<< 1;
        gy28       = (34'(wx_reg) + 34'(yz_reg)) <<< 1;
        gz28       = 34'(ww_reg) - 34'(xx_reg) - 34'(yy_reg) + 34'(zz_reg);
        yaw_y_next = (34'(xy_reg) - 34'(wz_reg)) <<< 1;
        yaw_x_next = ((35'(ww_reg) + 35'(xx_reg)) <<< 1) - ONE_Q28;
        gx_rnd     = (gx28 + 34'sd8192) >>> 14;
        gy_rnd     = (gy28 + 34'sd8192) >>> 14;
        gz_rnd     = (gz28 + 34'sd8192) >>> 14;
        sqx        = gx_reg * gx_reg;
        sqy        = gy_reg * gy_reg;
        sqz        = gz_reg * gz_reg;
        small_p    = sqy_reg * 11'd1049;
        small_r    = sqx_reg * 11'd1049;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg  <= s_tdata[15:0];
            x_reg  <= s_tdata[31:16];
            y_reg  <= s_tdata[47:32];
            z_reg  <= s_tdata[63:48];
            ww_reg <= w_reg * w_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            xz_reg <= x_reg * z_reg;
            wy_reg <= w_reg * y_reg;
            wx_reg <= w_reg * x_reg;
            yz_reg <= y_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            wz_reg <= w_reg * z_reg;
            gx_reg    <= gx_rnd[GW-1:0];
            gy_reg    <= gy_rnd[GW-1:0];
            gz_reg    <= gz_rnd[GW-1:0];
            yaw_y_reg <= yaw_y_next;
            yaw_x_reg <= yaw_x_next;
            sqx_reg <= sqx[RW-1:0];
            sqy_reg <= sqy[RW-1:0];
            sqz_reg <= sqz[RW-1:0];
            side_s3_reg.gx     <= gx_reg;
            side_s3_reg.gy     <= gy_reg;
            side_s3_reg.gz_pos <= (gz_reg > 20'sd0);
            side_s3_reg.grav   <= {sat16(gz_reg), sat16(gy_reg), sat16(gx_reg)};
            side_s3_reg.yaw_y  <= yaw_y_reg;
            side_s3_reg.yaw_x  <= yaw_x_reg;
            rad_p_reg   <= sqz_reg + RW'(small_p >> 20);
            rad_r_reg   <= sqz_reg + RW'(small_r >> 20);
            side_s4_reg <= side_s3_reg;
            side_reg[0] <= side_s4_reg;
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < SQ_STAGES; k++)
        begin : g_sqrt
            qtge_sqrt_cell #(.K(SQ_STAGES - 1 - k)) u_sqrt_p (
                .clk      (clk),
                .en       (en),
                .rem_in   ((k == 0) ? rad_p_reg : rem_p[(k == 0) ? 0 : k-1]),
                .root_in  ((k == 0) ? '0 : root_p[(k == 0) ? 0 : k-1]),
                .rem_out  (rem_p[k]),
                .root_out (root_p[k])
            );
            qtge_sqrt_cell #(.K(SQ_STAGES - 1 - k)) u_sqrt_r (
                .clk      (clk),
                .en       (en),
                .rem_in   ((k == 0) ? rad_r_reg : rem_r[(k == 0) ? 0 : k-1]),
                .root_in  ((k == 0) ? '0 : root_r[(k == 0) ? 0 : k-1]),
                .rem_out  (rem_r[k]),
                .root_out (root_r[k])
            );
        end
    endgenerate

    always_comb
    begin
        den_p = CW'($signed({1'b0, root_p[SQ_STAGES-1][SQ_STAGES-1:0]})) <<< 12;
        den_r = CW'($signed({1'b0, root_r[SQ_STAGES-1][SQ_STAGES-1:0]})) <<< 12;
        if (!side_reg[SQ_STAGES-1].gz_pos)
        begin
            den_p = -den_p;
            den_r = -den_r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg[0] <= pre_rotate(CW'(side_reg[SQ_STAGES-1].gy) <<< 12, den_r);
            pre_reg[1] <= pre_rotate(CW'(side_reg[SQ_STAGES-1].gx) <<< 12, den_p);
            pre_reg[2] <= pre_rotate(CW'(side_reg[SQ_STAGES-1].yaw_y),
                                     CW'(side_reg[SQ_STAGES-1].yaw_x));
            grav_reg[0] <= side_reg[SQ_STAGES-1].grav;
            for (int i = 1; i <= NS; i++)
            begin
                grav_reg[i] <= grav_reg[i-1];
            end
        end
    end

    genvar l, s;
    generate
        for (l = 0; l < 3; l++)
        begin : g_lane
            for (s = 0; s < NS; s++)
            begin : g_stage
                qtge_cordic_cell #(.STAGE(s)) u_cell (
                    .clk (clk),
                    .en  (en),
                    .d   ((s == 0) ? pre_reg[l] : lane_q[l][(s == 0) ? 0 : s-1]),
                    .q   (lane_q[l][s])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= {angle_out(lane_q[2][NS-1]), angle_out(lane_q[1][NS-1]),
                            angle_out(lane_q[0][NS-1]), grav_reg[NS]};
        end
    end

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_first_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && en) |=> vld_reg[1])
        else $error("word lost after input stage");

    a_last_stage_out: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[L-1] && en) |=> m_tvalid)
        else $error("word lost at output register");

endmodule

`default_nettype wire

// ===== design/qtge_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qtge_sqrt_cell
// one restoring square root step, one result bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module qtge_sqrt_cell
    import qtge_pkg::*;
#(
    parameter int K = 0
)
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [RW-1:0] rem_in,
    input  wire logic [RW-1:0] root_in,
    output logic      [RW-1:0] rem_out,
    output logic      [RW-1:0] root_out
);

    localparam logic [RW:0] BIT = {{RW{1'b0}}, 1'b1} << (2 * K);

    logic [RW:0]   trial;
    logic [RW-1:0] rem_next;
    logic [RW-1:0] root_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] root_reg;

    always_comb
    begin
        trial = {1'b0, root_in} + BIT;
        if ({1'b0, rem_in} >= trial)
        begin
            rem_next  = rem_in - trial[RW-1:0];
            root_next = (root_in >> 1) + BIT[RW-1:0];
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

// ===== design/qtge_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// qtge_cordic_cell
// one vectoring cordic micro-rotation with its output register
// ----------------------------------------------------------------------------
`default_nettype none

module qtge_cordic_cell
    import qtge_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire cordic_t d,
    output cordic_t      q
);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [AW-1:0] ang;
    cordic_t              q_next;
    cordic_t              q_reg;

    always_comb
    begin
        dx          = d.y >>> STAGE;
        dy          = d.x >>> STAGE;
        ang         = atan_entry(5'(STAGE));
        q_next.zero = d.zero;
        if (!d.y[CW-1])
        begin
            q_next.x   = d.x + dx;
            q_next.y   = d.y - dy;
            q_next.acc = d.acc + ang;
        end
        else
        begin
            q_next.x   = d.x - dx;
            q_next.y   = d.y + dy;
            q_next.acc = d.acc - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire
